### rtl/core/lsgrw_pkg.sv
package lsgrw_pkg;

  typedef enum logic [1:0] {
    MODE_CLOCK_FALL = 2'd0,
    MODE_SELECT_RISE = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  localparam logic [7:0] SYNC_MASK = 8'hF8;
  localparam logic [7:0] COORD_MASK = 8'h7F;
  localparam logic [7:0] COLUMN_LIMIT = 8'd16;
  localparam logic [7:0] ROW_STEP = 8'd32;

  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 32;
  localparam int ADDR_FIELD_W = 11;
  localparam int WIDE_ADDR_W = 16;

  typedef struct packed {
    logic       increment_flag;
    logic       extended_flag;
    logic [7:0] read_data;
    logic [7:0] write_data;
    logic [10:0] write_address;
    logic       write_valid;
  } result_t;

endpackage

### rtl/core/lcd_serial_graphics_ram_writer_unit.sv
// Channel  Direction  tdata (lowest bit first)                          tuser
// s_       in         select_level, serial_bit, read_address, 3 zeros   mode
// m_       out        write_valid, write_address, write_data,           none
//                     read_data, extended_flag, increment_flag, 2 zeros
// One transaction is taken in every cycle unless a stall holds it. Its result passes an input
// register, then the frame logic and the graphics RAM port, into the result register.
// After reset the graphics RAM is cleared, one byte per cycle, until all RAM_ROWS * ROW_BYTES
// bytes are zero; s_tready stays low throughout.
// A stall on m_tready holds the result register and, through s_tready, the input register.
module lcd_serial_graphics_ram_writer_unit #(
  parameter int RAM_ROWS = 64,
  parameter int ROW_BYTES = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // select_level, serial_bit, read_address, zero padding
  input  logic [lsgrw_pkg::IN_DATA_W-1:0]       s_tdata,
  // mode
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // write_valid, write_address, write_data, read_data, extended_flag,
  // increment_flag, zero padding
  output logic [lsgrw_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import lsgrw_pkg::*;

  localparam int RAM_SIZE = RAM_ROWS * ROW_BYTES;
  localparam int AW = $clog2(RAM_SIZE);
  localparam logic [WIDE_ADDR_W-1:0] RAM_SIZE_W = WIDE_ADDR_W'(RAM_SIZE);
  localparam logic [WIDE_ADDR_W-1:0] ROW_BYTES_W = WIDE_ADDR_W'(ROW_BYTES);
  localparam logic [8:0] RAM_ROWS_W = 9'(RAM_ROWS);
  localparam logic [8:0] ROW_LIMIT_W = 9'(ROW_BYTES);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(RAM_SIZE - 1);

  logic [7:0] mem [RAM_SIZE];

  logic          clearing;
  logic [AW-1:0] clear_count;

  logic        s1_valid;
  mode_t       s1_mode;
  logic        s1_sel;
  logic        s1_bit;
  logic [10:0] s1_raddr;
  logic        s1_adv;
  logic        s1_fire;

  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_count, bit_count_next;
  logic [1:0] byte_count, byte_count_next;
  logic [7:0] frame_sync, frame_sync_next;
  logic [7:0] frame_first, frame_first_next;
  logic       extended_set, extended_set_next;
  logic       entry_increment, entry_increment_next;
  logic       coord_phase, coord_phase_next;
  logic [7:0] row_address, row_address_next;
  logic [7:0] column_address, column_address_next;

  logic [7:0] shifted;
  logic [2:0] bit_inc;
  logic [1:0] slot;
  logic [7:0] frame_data;
  logic [7:0] col_inc;
  logic [7:0] col_double;
  logic       wr_en;
  logic [WIDE_ADDR_W-1:0] wr_wide;
  logic [WIDE_ADDR_W-1:0] rd_wide;
  logic       rd_ok;

  logic        out_wv;
  logic [10:0] out_wa;
  logic [7:0]  out_wd;
  logic [7:0]  rd_q;
  logic        out_rd_ok;
  logic        out_ext;
  logic        out_inc;
  result_t     result;

  assign s1_adv = !m_tvalid || m_tready;
  assign s1_fire = s1_valid && s1_adv;
  assign s_tready = !clearing && (!s1_valid || s1_adv);

  assign shifted = {shift_byte[6:0], s1_bit};
  assign bit_inc = bit_count + 3'd1;
  assign wr_wide = WIDE_ADDR_W'(row_address) * ROW_BYTES_W + WIDE_ADDR_W'(column_address);
  assign rd_wide = WIDE_ADDR_W'(s1_raddr);
  assign rd_ok = (s1_mode == MODE_READ) && (rd_wide < RAM_SIZE_W);
  assign col_inc = column_address + 8'd1;

  always_comb begin
    shift_byte_next = shift_byte;
    bit_count_next = bit_count;
    byte_count_next = byte_count;
    frame_sync_next = frame_sync;
    frame_first_next = frame_first;
    extended_set_next = extended_set;
    entry_increment_next = entry_increment;
    coord_phase_next = coord_phase;
    row_address_next = row_address;
    column_address_next = column_address;
    slot = byte_count;
    frame_data = frame_first | (shifted >> 4);
    col_double = {frame_data[6:0], 1'b0};
    wr_en = 1'b0;
    case (s1_mode)
      MODE_CLOCK_FALL: begin
        if (s1_sel) begin
          bit_count_next = bit_inc;
          shift_byte_next = shifted;
          if (bit_inc == 3'd0) begin
            shift_byte_next = '0;
            if (slot == 2'd0 && (shifted & SYNC_MASK) != SYNC_MASK) begin
              slot = 2'd1;
            end
            if (slot == 2'd3) begin
              slot = 2'd2;
            end
            byte_count_next = slot + 2'd1;
            if (slot == 2'd0) begin
              frame_sync_next = shifted;
            end else if (slot == 2'd1) begin
              frame_first_next = shifted;
            end else begin
              byte_count_next = 2'd0;
              if (frame_sync[1]) begin
                wr_en = ({1'b0, row_address} < RAM_ROWS_W)
                        && ({1'b0, column_address} < ROW_LIMIT_W);
                column_address_next = ({1'b0, col_inc} >= ROW_LIMIT_W) ? 8'd0 : col_inc;
              end else if (extended_set) begin
                if (frame_data[7]) begin
                  if (!coord_phase) begin
                    row_address_next = frame_data & COORD_MASK;
                    coord_phase_next = 1'b1;
                  end else begin
                    coord_phase_next = 1'b0;
                    column_address_next = col_double;
                    if (col_double >= COLUMN_LIMIT) begin
                      column_address_next = 8'd0;
                      row_address_next = row_address + ROW_STEP;
                    end
                  end
                end else if (!frame_data[6] && frame_data[5]) begin
                  extended_set_next = frame_data[2];
                end
              end else begin
                if (frame_data[7:6] == 2'b00) begin
                  if (frame_data[5]) begin
                    extended_set_next = frame_data[2];
                  end else if (frame_data[4:3] == 2'b00 && frame_data[2]) begin
                    entry_increment_next = frame_data[0];
                  end
                end
              end
            end
          end
        end
      end
      MODE_SELECT_RISE: begin
        bit_count_next = '0;
        byte_count_next = '0;
        shift_byte_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clear_count <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      shift_byte <= '0;
      bit_count <= '0;
      byte_count <= '0;
      frame_sync <= '0;
      frame_first <= '0;
      extended_set <= 1'b0;
      entry_increment <= 1'b0;
      coord_phase <= 1'b0;
      row_address <= '0;
      column_address <= '0;
    end else begin
      if (clearing) begin
        clear_count <= clear_count + AW'(1);
        if (clear_count == CLEAR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_adv) begin
        m_tvalid <= s1_valid;
      end
      if (s1_fire) begin
        shift_byte <= shift_byte_next;
        bit_count <= bit_count_next;
        byte_count <= byte_count_next;
        frame_sync <= frame_sync_next;
        frame_first <= frame_first_next;
        extended_set <= extended_set_next;
        entry_increment <= entry_increment_next;
        coord_phase <= coord_phase_next;
        row_address <= row_address_next;
        column_address <= column_address_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_mode <= mode_t'(s_tuser);
      s1_sel <= s_tdata[0];
      s1_bit <= s_tdata[1];
      s1_raddr <= s_tdata[12:2];
    end
    if (s1_fire) begin
      out_wv <= wr_en;
      out_wa <= wr_en ? wr_wide[ADDR_FIELD_W-1:0] : '0;
      out_wd <= wr_en ? frame_data : '0;
      out_rd_ok <= rd_ok;
      out_ext <= extended_set_next;
      out_inc <= entry_increment_next;
      rd_q <= mem[rd_wide[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_count] <= 8'd0;
    end else if (s1_fire && wr_en) begin
      mem[wr_wide[AW-1:0]] <= frame_data;
    end
  end

  always_comb begin
    result.write_valid = out_wv;
    result.write_address = out_wa;
    result.write_data = out_wd;
    result.read_data = out_rd_ok ? rd_q : 8'd0;
    result.extended_flag = out_ext;
    result.increment_flag = out_inc;
  end

  assign m_tdata = {2'b00, result};

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("Input accepted while the graphics RAM is being cleared.");

  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_mode == MODE_SELECT_RISE) |=> (bit_count == 3'd0 && byte_count == 2'd0))
    else $error("Chip select rise did not reset the framing.");

  assert property (@(posedge clk) disable iff (rst) byte_count != 2'd3)
    else $error("Byte counter passed the end of a frame.");

  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && wr_en) |-> (wr_wide < RAM_SIZE_W && !clearing))
    else $error("Graphics RAM write outside the store.");
`endif

endmodule
